// File: rtl/core/qyd_pkg.sv
package qyd_pkg;

  localparam int SLOTS_PER_REV = 448;
  localparam int COUNT_WIDTH   = 24;

  // Degrees per revolution, doubled so that the half-slot rounding stays integral.
  localparam int DEG_SCALE = 720;

  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 88;

  localparam int FIELD_W     = 24;
  localparam int WRAP_DEG_W  = 10;

  typedef enum logic [1:0] {
    CMD_PINS     = 2'd0,
    CMD_LOAD_ABS = 2'd1,
    CMD_LOAD_MAP = 2'd2,
    CMD_COMPUTE  = 2'd3
  } qyd_cmd_t;

  // Count and flag data that travels beside the degree pipeline.
  typedef struct packed {
    logic               comp;
    logic [FIELD_W-1:0] slot;
    logic [FIELD_W-1:0] wrap;
  } qyd_tag_t;

  // Next pin state in the forward direction of the sequence 00 -> 10 -> 11 -> 01.
  function automatic logic [1:0] next_up(input logic [1:0] pins);
    logic [1:0] nxt;
    unique case (pins)
      2'b00: nxt = 2'b10;
      2'b01: nxt = 2'b00;
      2'b10: nxt = 2'b11;
      2'b11: nxt = 2'b01;
      default: nxt = 2'b00;
    endcase
    return nxt;
  endfunction

  // Width that holds the magnitude of DEG_SCALE * count + slots.
  function automatic int num_width(input int cw);
    int w;
    w = (cw + 9 > 16) ? cw + 9 : 16;
    return w + 1;
  endfunction

  function automatic int deg_width(input int cw);
    int nw;
    nw = num_width(cw);
    return (nw > FIELD_W) ? nw : FIELD_W;
  endfunction

endpackage

// File: rtl/core/quadrature_yaw_decoder.sv
// Channel | Direction | Signals                          | Contents
// in      | slave     | in_tvalid in_tready in_tdata      | command, pin sample, load value
//         |           | in_tuser                         |
// out     | master    | out_tvalid out_tready out_tdata   | counts and degrees after the item
//
// One item is accepted per cycle while in_tready is high; each gives one result.
// The degree converter forms the signed numerator, then does a reciprocal multiply, a
// remainder step, a second reciprocal multiply and a sign restore, each in its own stage,
// between the count update register and the output register. Counts are updated at the
// cycle of acceptance. Reset (rst_n low, synchronous) clears the counts, the pin history,
// the degree registers and the pipeline. A stall at the output holds every full stage;
// empty stages ahead of it still fill, so input is taken as long as a bubble remains.
module quadrature_yaw_decoder #(
  parameter int SLOTS_PER_REV = qyd_pkg::SLOTS_PER_REV,
  parameter int COUNT_WIDTH   = qyd_pkg::COUNT_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // pins [1:0], load_value [25:2], zero [31:26]
  input  logic [qyd_pkg::IN_DATA_W-1:0]   in_tdata,
  // cmd [1:0]
  input  logic [qyd_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // slot_count [23:0], wrapped_count [47:24], total_degrees [71:48],
  // wrapped_degrees [81:72], zero [87:82]
  output logic [qyd_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam int NST = 7;
  localparam int OW  = qyd_pkg::deg_width(COUNT_WIDTH);
  localparam int FW  = qyd_pkg::FIELD_W;
  localparam int WW  = qyd_pkg::WRAP_DEG_W;

  qyd_pkg::qyd_cmd_t       cmd;
  logic [1:0]              pins;
  logic signed [32:0]      lv_wide;
  logic [COUNT_WIDTH-1:0]  lv;
  logic signed [32:0]      map_wide;
  logic                    map_clr;
  logic                    accept;

  logic [1:0]              last_pins_r;
  logic [1:0]              last_pins_nxt;
  logic [COUNT_WIDTH-1:0]  abs_count_r;
  logic [COUNT_WIDTH-1:0]  abs_count_nxt;
  logic [COUNT_WIDTH-1:0]  map_count_r;
  logic [COUNT_WIDTH-1:0]  map_count_nxt;
  logic [31:0]             abs_ext;
  logic [31:0]             map_ext;

  logic [NST-1:0]          en;
  logic [NST-1:0]          v_r;
  qyd_pkg::qyd_tag_t       tag_nxt;
  qyd_pkg::qyd_tag_t       tag_r [NST];
  logic [COUNT_WIDTH-1:0]  st0_abs_r;
  logic [COUNT_WIDTH-1:0]  st0_map_r;

  logic [OW-1:0]           abs_deg;
  logic [OW-1:0]           map_deg;
  logic [FW-1:0]           abs_deg_r;
  logic [WW-1:0]           map_deg_r;

  assign cmd      = qyd_pkg::qyd_cmd_t'(in_tuser);
  assign pins     = in_tdata[1:0];
  assign lv_wide  = 33'($signed(in_tdata[25:2]));
  assign lv       = lv_wide[COUNT_WIDTH-1:0];
  assign map_wide = 33'($signed(map_count_r));
  assign map_clr  = (map_wide >= 33'(SLOTS_PER_REV)) || (map_wide <= -33'(SLOTS_PER_REV));
  assign accept   = in_tvalid && in_tready;

  // A stage may load when it is empty or when the stage after it moves on.
  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_tready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_tready = en[0];

  always_comb begin
    last_pins_nxt = last_pins_r;
    abs_count_nxt = abs_count_r;
    map_count_nxt = map_count_r;
    if (accept) begin
      unique case (cmd)
        qyd_pkg::CMD_PINS: begin
          if (pins == qyd_pkg::next_up(last_pins_r)) begin
            abs_count_nxt = abs_count_r + 1'b1;
            map_count_nxt = map_count_r + 1'b1;
          end else if (last_pins_r == qyd_pkg::next_up(pins)) begin
            abs_count_nxt = abs_count_r - 1'b1;
            map_count_nxt = map_count_r - 1'b1;
          end
          last_pins_nxt = pins;
        end
        qyd_pkg::CMD_LOAD_ABS: begin
          abs_count_nxt = lv;
        end
        qyd_pkg::CMD_LOAD_MAP: begin
          map_count_nxt = lv;
        end
        qyd_pkg::CMD_COMPUTE: begin
          if (map_clr) begin
            map_count_nxt = '0;
          end
        end
      endcase
    end
  end

  // The count fields show the low bits of the unsigned count word.
  assign abs_ext = 32'(abs_count_nxt);
  assign map_ext = 32'(map_count_nxt);

  always_comb begin
    tag_nxt.comp = (cmd == qyd_pkg::CMD_COMPUTE);
    tag_nxt.slot = abs_ext[FW-1:0];
    tag_nxt.wrap = map_ext[FW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pins_r <= '0;
      abs_count_r <= '0;
      map_count_r <= '0;
      abs_deg_r   <= '0;
      map_deg_r   <= '0;
      v_r         <= '0;
    end else begin
      last_pins_r <= last_pins_nxt;
      abs_count_r <= abs_count_nxt;
      map_count_r <= map_count_nxt;
      if (en[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int i = 1; i < NST; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
      // The degree registers change in item order, as a compute item reaches the output.
      if (en[NST-1] && v_r[NST-2] && tag_r[NST-2].comp) begin
        abs_deg_r <= abs_deg[FW-1:0];
        map_deg_r <= map_deg[WW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      tag_r[0]  <= tag_nxt;
      st0_abs_r <= abs_count_nxt;
      st0_map_r <= map_count_nxt;
    end
    for (int i = 1; i < NST; i++) begin
      if (en[i]) begin
        tag_r[i] <= tag_r[i-1];
      end
    end
  end

  qyd_deg_conv #(
    .COUNT_WIDTH   (COUNT_WIDTH),
    .SLOTS_PER_REV (SLOTS_PER_REV)
  ) u_abs_conv (
    .clk     (clk),
    .en_i    (en[5:1]),
    .count_i (st0_abs_r),
    .deg_o   (abs_deg)
  );

  qyd_deg_conv #(
    .COUNT_WIDTH   (COUNT_WIDTH),
    .SLOTS_PER_REV (SLOTS_PER_REV)
  ) u_map_conv (
    .clk     (clk),
    .en_i    (en[5:1]),
    .count_i (st0_map_r),
    .deg_o   (map_deg)
  );

  assign out_tvalid = v_r[NST-1];
  assign out_tdata  = {6'b0, map_deg_r, abs_deg_r, tag_r[NST-1].wrap, tag_r[NST-1].slot};

endmodule

// File: rtl/core/qyd_deg_conv.sv
module qyd_deg_conv #(
  parameter int COUNT_WIDTH   = qyd_pkg::COUNT_WIDTH,
  parameter int SLOTS_PER_REV = qyd_pkg::SLOTS_PER_REV
) (
  input  logic                                        clk,
  input  logic [4:0]                                  en_i,
  input  logic [COUNT_WIDTH-1:0]                      count_i,
  output logic [qyd_pkg::deg_width(COUNT_WIDTH)-1:0]  deg_o
);

  localparam int D   = 2 * SLOTS_PER_REV;
  localparam int RW  = $clog2(D);
  localparam int NW  = qyd_pkg::num_width(COUNT_WIDTH);
  localparam int OW  = qyd_pkg::deg_width(COUNT_WIDTH);
  // The magnitude is divided in two chunks: a high part, then the remainder joined
  // to the low part. Each chunk stays within a 32-bit reciprocal multiply.
  localparam int K1  = (32 - RW < NW - 1) ? 32 - RW : NW - 1;
  localparam int N0  = NW - K1;
  localparam int N1  = RW + K1;
  localparam int SH0 = N0 + RW;
  localparam int SH1 = N1 + RW;
  localparam int P0  = 2 * N0 + 1;
  localparam int P1  = 2 * N1 + 1;
  localparam int TW  = N0 + RW + 1;

  localparam logic [63:0] M0_FULL = ((64'd1 << SH0) + 64'(D) - 64'd1) / 64'(D);
  localparam logic [63:0] M1_FULL = ((64'd1 << SH1) + 64'(D) - 64'd1) / 64'(D);
  localparam logic [N0:0] M0 = M0_FULL[N0:0];
  localparam logic [N1:0] M1 = M1_FULL[N1:0];

  logic signed [NW:0] c_ext;
  logic signed [NW:0] num;
  logic signed [NW:0] num_abs;
  logic               s1_neg_r;
  logic [NW-1:0]      s1_x_r;

  logic [N0-1:0]      x_hi;
  logic [P0-1:0]      prod0;
  logic [N0-1:0]      q0_nxt;
  logic               s2_neg_r;
  logic [N0-1:0]      s2_q0_r;
  logic [N0-1:0]      s2_xhi_r;
  logic [K1-1:0]      s2_xlo_r;

  logic [TW-1:0]      prodd;
  logic [TW-1:0]      rem;
  logic [N1-1:0]      x1_nxt;
  logic               s3_neg_r;
  logic [N0-1:0]      s3_q0_r;
  logic [N1-1:0]      s3_x1_r;

  logic [P1-1:0]      prod1;
  logic [K1-1:0]      q1_nxt;
  logic               s4_neg_r;
  logic [NW-1:0]      s4_q_r;

  logic [OW-1:0]      q_ext;
  logic [OW-1:0]      deg_nxt;
  logic [OW-1:0]      deg_r;

  // Stage 1: signed numerator and its magnitude.
  always_comb begin
    c_ext   = (NW + 1)'($signed(count_i));
    num     = c_ext * (NW + 1)'(qyd_pkg::DEG_SCALE) + (NW + 1)'(SLOTS_PER_REV);
    num_abs = num[NW] ? -num : num;
  end

  // Stage 2: quotient of the high chunk.
  always_comb begin
    x_hi   = s1_x_r[NW-1:K1];
    prod0  = P0'(x_hi) * P0'(M0);
    q0_nxt = N0'(prod0 >> SH0);
  end

  // Stage 3: remainder of the high chunk, joined to the low chunk.
  always_comb begin
    prodd  = TW'(s2_q0_r) * TW'(D);
    rem    = TW'(s2_xhi_r) - prodd;
    x1_nxt = {rem[RW-1:0], s2_xlo_r};
  end

  // Stage 4: quotient of the low chunk; it always fits below 2**K1.
  always_comb begin
    prod1  = P1'(s3_x1_r) * P1'(M1);
    q1_nxt = K1'(prod1 >> SH1);
  end

  // Stage 5: restore the sign, truncating toward zero.
  always_comb begin
    q_ext   = OW'(s4_q_r);
    deg_nxt = s4_neg_r ? -q_ext : q_ext;
  end

  always_ff @(posedge clk) begin
    if (en_i[0]) begin
      s1_neg_r <= num[NW];
      s1_x_r   <= num_abs[NW-1:0];
    end
    if (en_i[1]) begin
      s2_neg_r <= s1_neg_r;
      s2_q0_r  <= q0_nxt;
      s2_xhi_r <= x_hi;
      s2_xlo_r <= s1_x_r[K1-1:0];
    end
    if (en_i[2]) begin
      s3_neg_r <= s2_neg_r;
      s3_q0_r  <= s2_q0_r;
      s3_x1_r  <= x1_nxt;
    end
    if (en_i[3]) begin
      s4_neg_r <= s3_neg_r;
      s4_q_r   <= {s3_q0_r, q1_nxt};
    end
    if (en_i[4]) begin
      deg_r <= deg_nxt;
    end
  end

  assign deg_o = deg_r;

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int CW           = qyd_pkg::COUNT_WIDTH;
  localparam int SPR          = qyd_pkg::SLOTS_PER_REV;
  localparam int RANDOM_ITEMS = 900;
  localparam int DRAIN_CYCLES = 20;
  localparam int QUIET_LIMIT  = 2000;

  typedef struct packed {
    logic [23:0] slot;
    logic [23:0] wrap;
    logic [23:0] tdeg;
    logic [9:0]  wdeg;
  } yaw_result_t;

  typedef struct packed {
    qyd_pkg::qyd_cmd_t cmd;
    logic [1:0]        pins;
    logic [23:0]       lv;
    logic              typed;
    yaw_result_t       result;
  } stim_row_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [qyd_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic [qyd_pkg::IN_USER_W-1:0]  in_tuser = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [qyd_pkg::OUT_DATA_W-1:0] out_tdata;

  // Typed expectation that travels with the item currently offered.
  logic        row_typed = 1'b0;
  yaw_result_t row_result = '0;

  // Predictor state.
  logic [1:0]    pred_pins = '0;
  logic [CW-1:0] pred_abs = '0;
  logic [CW-1:0] pred_map = '0;
  logic [23:0]   pred_abs_deg = '0;
  logic [9:0]    pred_map_deg = '0;

  yaw_result_t pending_results[$];
  stim_row_t   directed_rows[$];
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  int          burst_left = 0;
  int          stall_left = 0;
  int          open_left = 0;
  logic [1:0]  sent_pins = 2'b00;

  quadrature_yaw_decoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Forward direction of the Gray walk is 00 -> 10 -> 11 -> 01 -> 00.
  function automatic logic [1:0] step_fwd(input logic [1:0] p);
    case (p)
      2'b00: return 2'b10;
      2'b10: return 2'b11;
      2'b11: return 2'b01;
      default: return 2'b00;
    endcase
  endfunction

  function automatic logic [1:0] step_back(input logic [1:0] p);
    case (p)
      2'b00: return 2'b01;
      2'b01: return 2'b11;
      2'b11: return 2'b10;
      default: return 2'b00;
    endcase
  endfunction

  function automatic longint count_to_deg(input logic [CW-1:0] cnt);
    longint c;
    longint num;
    c = longint'($signed(cnt));
    num = 720 * c + SPR;
    return (num / 2) / SPR;
  endfunction

  function automatic yaw_result_t predict_yaw(input qyd_pkg::qyd_cmd_t cmd,
                                              input logic [1:0] pins,
                                              input logic [23:0] lv);
    yaw_result_t res;
    longint      m;
    case (cmd)
      qyd_pkg::CMD_PINS: begin
        if (pins == step_fwd(pred_pins)) begin
          pred_abs = pred_abs + 1'b1;
          pred_map = pred_map + 1'b1;
        end else if (pred_pins == step_fwd(pins)) begin
          pred_abs = pred_abs - 1'b1;
          pred_map = pred_map - 1'b1;
        end
        pred_pins = pins;
      end
      qyd_pkg::CMD_LOAD_ABS: pred_abs = CW'(longint'($signed(lv)));
      qyd_pkg::CMD_LOAD_MAP: pred_map = CW'(longint'($signed(lv)));
      default: begin
        m = longint'($signed(pred_map));
        if (m >= SPR || m <= -SPR) pred_map = '0;
        pred_abs_deg = 24'(count_to_deg(pred_abs));
        pred_map_deg = 10'(count_to_deg(pred_map));
      end
    endcase
    res.slot = 24'(pred_abs);
    res.wrap = 24'(pred_map);
    res.tdeg = pred_abs_deg;
    res.wdeg = pred_map_deg;
    return res;
  endfunction

  function automatic logic [23:0] pick_load();
    logic [23:0] v;
    case ($urandom_range(0, 7))
      0: v = 24'h7FFFFF - 24'($urandom_range(0, 6));
      1: v = 24'h800000 + 24'($urandom_range(0, 6));
      2, 3: begin
        // Around one revolution, so the clear at compute falls on both sides.
        v = 24'(SPR - 4 + $urandom_range(0, 8));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      4: v = 24'($urandom_range(0, 2000)) - 24'd1000;
      default: v = 24'($urandom);
    endcase
    return v;
  endfunction

  task automatic add_row(input qyd_pkg::qyd_cmd_t cmd, input logic [1:0] pins,
                         input logic [23:0] lv,
                         input logic typed, input logic [23:0] slot, wrap, tdeg,
                         input logic [9:0] wdeg);
    stim_row_t row;
    row.cmd = cmd;
    row.pins = pins;
    row.lv = lv;
    row.typed = typed;
    row.result.slot = slot;
    row.result.wrap = wrap;
    row.result.tdeg = tdeg;
    row.result.wdeg = wdeg;
    directed_rows.push_back(row);
  endtask

  task automatic push_item(input stim_row_t row);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else if (r < 65) begin
      gap = 0;
    end else if (r < 88) begin
      gap = $urandom_range(1, 3);
    end else if (r < 96) begin
      gap = $urandom_range(4, 10);
    end else if (r < 98) begin
      gap = $urandom_range(15, 40);
    end else begin
      burst_left = $urandom_range(30, 120);
      gap = 0;
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= row.cmd;
    in_tdata <= {{(qyd_pkg::IN_DATA_W-26){1'b0}}, row.lv, row.pins};
    row_typed <= row.typed;
    row_result <= row.result;
    if (row.cmd == qyd_pkg::CMD_PINS) sent_pins = row.pins;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic check_field(input string fname, input logic [23:0] want, got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, fname, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : receiver
    int r;
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (open_left > 0) begin
      out_tready <= 1'b1;
      open_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        out_tready <= 1'b1;
      end else if (r < 88) begin
        out_tready <= 1'b0;
        stall_left = $urandom_range(0, 2);
      end else if (r < 95) begin
        out_tready <= 1'b0;
        stall_left = $urandom_range(8, 40);
      end else begin
        out_tready <= 1'b1;
        open_left = $urandom_range(40, 150);
      end
    end
  end

  always @(posedge clk) begin : scoreboard
    yaw_result_t want;
    yaw_result_t got;
    if (rst_n) begin
      // Predict first, so an item and its own result in one cycle would still line up.
      if (in_tvalid && in_tready) begin
        want = predict_yaw(qyd_pkg::qyd_cmd_t'(in_tuser), in_tdata[1:0], in_tdata[25:2]);
        if (row_typed) want = row_result;
        pending_results.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got.slot = out_tdata[23:0];
        got.wrap = out_tdata[47:24];
        got.tdeg = out_tdata[71:48];
        got.wdeg = out_tdata[81:72];
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing expected, got %h", $time, got);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("slot_count", want.slot, got.slot);
          check_field("wrapped_count", want.wrap, got.wrap);
          check_field("total_degrees", want.tdeg, got.tdeg);
          check_field("wrapped_degrees", 24'(want.wdeg), 24'(got.wdeg));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    stim_row_t row;
    int        r;
    int        k;
    logic      fwd_walk;

    fwd_walk = 1'b1;
    // Compute straight after reset, then one full forward turn of the pins.
    add_row(qyd_pkg::CMD_COMPUTE,  2'b11, 24'h5A5A5A, 1'b1, 24'd0, 24'd0, 24'd0, 10'd0);
    add_row(qyd_pkg::CMD_PINS,     2'b10, 24'hFFFFFF, 1'b1, 24'd1, 24'd1, 24'd0, 10'd0);
    add_row(qyd_pkg::CMD_PINS,     2'b11, 24'h000000, 1'b1, 24'd2, 24'd2, 24'd0, 10'd0);
    add_row(qyd_pkg::CMD_PINS,     2'b01, 24'hA5A5A5, 1'b1, 24'd3, 24'd3, 24'd0, 10'd0);
    add_row(qyd_pkg::CMD_PINS,     2'b00, 24'h800000, 1'b1, 24'd4, 24'd4, 24'd0, 10'd0);
    // Unchanged pins, then a jump of two states.
    add_row(qyd_pkg::CMD_PINS,     2'b00, 24'h7FFFFF, 1'b1, 24'd4, 24'd4, 24'd0, 10'd0);
    add_row(qyd_pkg::CMD_PINS,     2'b11, 24'h000000, 1'b1, 24'd4, 24'd4, 24'd0, 10'd0);
    // Backward steps down through zero.
    add_row(qyd_pkg::CMD_PINS,     2'b10, 24'h000000, 1'b1, 24'd3, 24'd3, 24'd0, 10'd0);
    add_row(qyd_pkg::CMD_PINS,     2'b00, 24'h000000, 1'b1, 24'd2, 24'd2, 24'd0, 10'd0);
    add_row(qyd_pkg::CMD_PINS,     2'b01, 24'h000000, 1'b1, 24'd1, 24'd1, 24'd0, 10'd0);
    add_row(qyd_pkg::CMD_PINS,     2'b11, 24'h000000, 1'b1, 24'd0, 24'd0, 24'd0, 10'd0);
    add_row(qyd_pkg::CMD_PINS,     2'b10, 24'h000000, 1'b1,
            24'hFFFFFF, 24'hFFFFFF, 24'd0, 10'd0);
    // Largest absolute count, then one step up wraps it to the most negative value.
    add_row(qyd_pkg::CMD_LOAD_ABS, 2'b01, 24'h7FFFFF, 1'b1,
            24'h7FFFFF, 24'hFFFFFF, 24'd0, 10'd0);
    add_row(qyd_pkg::CMD_PINS,     2'b11, 24'h000000, 1'b1,
            24'h800000, 24'h000000, 24'd0, 10'd0);
    add_row(qyd_pkg::CMD_COMPUTE,  2'b00, 24'h123456, 1'b0, 24'd0, 24'd0, 24'd0, 10'd0);
    // Mapped count on and just inside one revolution, both signs.
    add_row(qyd_pkg::CMD_LOAD_MAP, 2'b11, 24'h0001C0, 1'b0, 24'd0, 24'd0, 24'd0, 10'd0);
    add_row(qyd_pkg::CMD_COMPUTE,  2'b10, 24'hFFFFFF, 1'b0, 24'd0, 24'd0, 24'd0, 10'd0);
    add_row(qyd_pkg::CMD_LOAD_MAP, 2'b00, 24'hFFFE40, 1'b0, 24'd0, 24'd0, 24'd0, 10'd0);
    add_row(qyd_pkg::CMD_COMPUTE,  2'b01, 24'h000000, 1'b0, 24'd0, 24'd0, 24'd0, 10'd0);
    add_row(qyd_pkg::CMD_LOAD_MAP, 2'b10, 24'h0001BF, 1'b0, 24'd0, 24'd0, 24'd0, 10'd0);
    add_row(qyd_pkg::CMD_COMPUTE,  2'b11, 24'h000000, 1'b0, 24'd0, 24'd0, 24'd0, 10'd0);
    add_row(qyd_pkg::CMD_LOAD_MAP, 2'b01, 24'hFFFE41, 1'b0, 24'd0, 24'd0, 24'd0, 10'd0);
    add_row(qyd_pkg::CMD_COMPUTE,  2'b00, 24'hC0FFEE, 1'b0, 24'd0, 24'd0, 24'd0, 10'd0);
    // Most negative mapped count, one step down wraps it to the largest.
    add_row(qyd_pkg::CMD_LOAD_MAP, 2'b00, 24'h800000, 1'b0, 24'd0, 24'd0, 24'd0, 10'd0);
    add_row(qyd_pkg::CMD_PINS,     2'b10, 24'h3C3C3C, 1'b0, 24'd0, 24'd0, 24'd0, 10'd0);
    add_row(qyd_pkg::CMD_COMPUTE,  2'b01, 24'h000000, 1'b0, 24'd0, 24'd0, 24'd0, 10'd0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) push_item(directed_rows[i]);

    // Mostly walks along the Gray sequence so the counts travel far, with
    // loads and computes mixed in; unused fields carry random values.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      row = '0;
      row.pins = 2'($urandom_range(0, 3));
      row.lv = 24'($urandom);
      r = $urandom_range(0, 99);
      if (r < 58) begin
        row.cmd = qyd_pkg::CMD_PINS;
        if ($urandom_range(0, 9) == 0) fwd_walk = !fwd_walk;
        k = $urandom_range(0, 19);
        if (k < 16) row.pins = fwd_walk ? step_fwd(sent_pins) : step_back(sent_pins);
        else if (k < 18) row.pins = sent_pins;
        else row.pins = ~sent_pins;
      end else if (r < 67) begin
        row.cmd = qyd_pkg::CMD_LOAD_ABS;
        row.lv = pick_load();
      end else if (r < 78) begin
        row.cmd = qyd_pkg::CMD_LOAD_MAP;
        row.lv = pick_load();
      end else begin
        row.cmd = qyd_pkg::CMD_COMPUTE;
      end
      push_item(row);
    end

    in_tvalid <= 1'b0;
    // Step the clock so the last accepted item is already queued.
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: files.f
rtl/core/qyd_pkg.sv
rtl/core/qyd_deg_conv.sv
rtl/core/quadrature_yaw_decoder.sv
tb/sv/testbench.sv
